### sv/assert_macros.svh
// Assertion macros used by the top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked on every rising clock edge outside reset.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
// Next-cycle implication checked outside reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

### sv/amis_pkg.sv
// Package: widths, lane count and word types of the abs-max index search.
package amis_pkg;
  localparam int unsigned Lanes = 4;
  localparam int unsigned IdxW = 31;
  localparam int unsigned MagW = 31;
  localparam int unsigned ValW = 32;

  typedef logic [ValW-1:0] val_t;
  typedef logic [MagW-1:0] mag_t;
  typedef logic [IdxW-1:0] idx_t;

  // Per-lane best held by each lane
  typedef struct packed {
    mag_t mag;
    idx_t idx;
  } best_t;
endpackage

### sv/amis_if.sv
// Interfaces: input vector word, result word and length write channel.
interface amis_in_if;
  logic            valid;
  logic            ready;
  amis_pkg::val_t  value_0;
  amis_pkg::val_t  value_1;
  amis_pkg::val_t  value_2;
  amis_pkg::val_t  value_3;
  modport source (output valid, value_0, value_1, value_2, value_3, input ready);
  modport sink   (input valid, value_0, value_1, value_2, value_3, output ready);
endinterface

interface amis_out_if;
  logic           valid;
  logic           ready;
  amis_pkg::idx_t max_index;
  amis_pkg::mag_t max_magnitude;
  modport source (output valid, max_index, max_magnitude, input ready);
  modport sink   (input valid, max_index, max_magnitude, output ready);
endinterface

interface amis_cfg_if;
  logic                       valid;
  logic                       ready;
  logic [amis_pkg::IdxW-1:0]  data;
  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

### sv/amis_lane.sv
// One lane: keeps the largest magnitude seen and its element index.
module amis_lane (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            step_i,
  input  logic            clear_i,
  input  logic            elem_ok_i,
  input  amis_pkg::val_t  value_i,
  input  amis_pkg::idx_t  index_i,
  output amis_pkg::best_t best_o,
  output amis_pkg::best_t next_o
);
  amis_pkg::best_t best_q, best_d;
  amis_pkg::mag_t  mag;

  // Sign-cleared compare; only strictly larger replaces
  always_comb begin
    mag = value_i[amis_pkg::MagW-1:0];
    next_o = best_q;
    if (elem_ok_i && (mag > best_q.mag)) begin
      next_o.mag = mag;
      next_o.idx = index_i;
    end
    best_d = best_q;
    if (step_i) best_d = clear_i ? '0 : next_o;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) best_q <= '0;
    else         best_q <= best_d;
  end

  assign best_o = best_q;
endmodule

### sv/amis_merge.sv
// Merge stage: registered chain of compares picking the largest, lowest index.
module amis_merge (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            load_i,
  input  amis_pkg::best_t lane_i [amis_pkg::Lanes],
  output amis_pkg::best_t win_o
);
  amis_pkg::best_t win_q, win_d;

  function automatic amis_pkg::best_t pick(amis_pkg::best_t a, amis_pkg::best_t b);
    if (b.mag > a.mag || (b.mag == a.mag && b.idx < a.idx)) return b;
    return a;
  endfunction

  // Few lanes: a short chain of compares
  always_comb begin
    win_d = lane_i[0];
    for (int j = 1; j < amis_pkg::Lanes; j++) win_d = pick(win_d, lane_i[j]);
  end

  always_ff @(posedge clk_i) begin
    if (load_i) win_q <= win_d;
  end

  assign win_o = win_q;
  logic unused_rst;
  assign unused_rst = rst_ni;
endmodule

### sv/abs_max_index_search.sv
// Top level: streaming abs-max index search over a vector of singles.
// Usage:
//   in_if carries one word of four single-precision lanes; element
//   elements_seen + j sits in lane j. cfg_if writes the vector length
//   (reset 1), accepted in any cycle; a new length applies from the next
//   input word. out_if gives one word per vector: index of the first
//   largest magnitude and that magnitude.
// Throughput: one input word per cycle, also across vector boundaries,
//   except in a stall; lanes compare in parallel, update in the same cycle.
// Result: the result word is valid in the cycle after the final input
//   word is accepted; the merge of the lanes is registered once.
// Stall: the result register holds while out ready is low. A new final
//   word is then refused until the result is taken; other words flow.
// Reset: lane bests, element count and result valid clear at once;
//   the length returns to 1.
`include "assert_macros.svh"
module abs_max_index_search (
  input  logic clk_i,
  input  logic rst_ni,
  amis_in_if.sink    in_if,
  amis_out_if.source out_if,
  amis_cfg_if.sink   cfg_if
);
  localparam int unsigned L = amis_pkg::Lanes;

  amis_pkg::idx_t  len_q, seen_q, seen_d;
  logic            oval_q, oval_d;
  logic            acc, last;
  logic [amis_pkg::IdxW:0] nxt;
  amis_pkg::val_t  vals [4];
  amis_pkg::best_t best [L];
  amis_pkg::best_t nbest [L];
  amis_pkg::best_t win;

  assign vals[0] = in_if.value_0;
  assign vals[1] = in_if.value_1;
  assign vals[2] = in_if.value_2;
  assign vals[3] = in_if.value_3;

  // Last word of vector when base + lanes reaches length
  assign nxt  = {1'b0, seen_q} + (amis_pkg::IdxW+1)'(L);
  assign last = !(nxt < {1'b0, len_q});
  assign in_if.ready = !last || !oval_q || out_if.ready;
  assign acc  = in_if.valid && in_if.ready;

  // Lanes
  for (genvar j = 0; j < L; j++) begin : g_lane
    logic [amis_pkg::IdxW:0] ix;
    assign ix = {1'b0, seen_q} + (amis_pkg::IdxW+1)'(j);
    amis_lane u_lane (
      .clk_i, .rst_ni, .step_i(acc), .clear_i(last),
      .elem_ok_i(ix < {1'b0, len_q}), .value_i(vals[j]),
      .index_i(ix[amis_pkg::IdxW-1:0]), .best_o(best[j]), .next_o(nbest[j])
    );
  end

  amis_merge u_merge (
    .clk_i, .rst_ni, .load_i(acc && last), .lane_i(nbest), .win_o(win)
  );

  // Element count and result valid
  always_comb begin
    seen_d = seen_q;
    if (acc) seen_d = last ? '0 : nxt[amis_pkg::IdxW-1:0];
    oval_d = oval_q;
    if (out_if.ready) oval_d = 1'b0;
    if (acc && last) oval_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q  <= amis_pkg::idx_t'(1);
      seen_q <= '0;
      oval_q <= 1'b0;
    end else begin
      seen_q <= seen_d;
      oval_q <= oval_d;
      if (cfg_if.valid) len_q <= cfg_if.data;
    end
  end

  assign cfg_if.ready         = 1'b1;
  assign out_if.valid         = oval_q;
  assign out_if.max_index     = win.idx;
  assign out_if.max_magnitude = win.mag;

  `ASSERT_NEXT(a_res_after_last, clk_i, rst_ni, acc && last, out_if.valid)
  `ASSERT_IMPL(a_no_overwrite, clk_i, rst_ni, out_if.valid && !out_if.ready && last, !in_if.ready)
  `ASSERT_NEXT(a_clear_after_last, clk_i, rst_ni, acc && last, seen_q == '0 && best[0] == '0)
endmodule
